FILE: hw/rtl/fwi_pkg.sv
// ----------------------------------------------------------------------------
// Frame window interleaver package
// Shared types and fixed widths of the frame window interleaver.
// ----------------------------------------------------------------------------
package fwi_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] t_word;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

endpackage

FILE: hw/rtl/fwi_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fwi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AddrW-1:0] i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AddrW-1:0] i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/frame_window_interleaver_unit.sv
// ----------------------------------------------------------------------------
// Frame window interleaver
// Keeps a sliding window of range-bin frames in a RAM and, after each frame,
// reads the whole window out bin-major, oldest frame first.
//
//   Channel | Handshake                 | Payload
//   --------+---------------------------+-----------------------------------
//   in      | i_in_valid / o_in_stall   | i_bin_value
//   out     | o_out_valid / i_out_stall | o_window_value, o_is_last
//
// A bin that does not close a frame is written straight into the RAM. The
// closing bin starts a readout of BINS_PER_FRAME * FRAMES_IN_WINDOW items,
// one per cycle from the single RAM read port while the output does not
// stall; the input is stalled until the last RAM read of the readout is issued.
// Reset is synchronous; it empties the window at once through per-entry
// valid bits, so never-written entries read as zero. Output stalls hold the
// readout through an output register and a skid register.
// ----------------------------------------------------------------------------
module frame_window_interleaver_unit #(
    parameter int BINS_PER_FRAME   = 8,
    parameter int FRAMES_IN_WINDOW = 8,
    localparam int Depth = BINS_PER_FRAME * FRAMES_IN_WINDOW,
    localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1,
    localparam int BinW  = (BINS_PER_FRAME > 1) ? $clog2(BINS_PER_FRAME) : 1,
    localparam int SlotW = (FRAMES_IN_WINDOW > 1) ? $clog2(FRAMES_IN_WINDOW) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [31:0]         i_bin_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [31:0]         o_window_value,
    output logic                o_is_last
);

    localparam logic [BinW-1:0]  LastBin  = BinW'(BINS_PER_FRAME - 1);
    localparam logic [SlotW-1:0] LastSlot = SlotW'(FRAMES_IN_WINDOW - 1);

    fwi_pkg::t_state r_state, n_state;
    logic [BinW-1:0]  r_wbin, n_wbin;
    logic [SlotW-1:0] r_oldest, n_oldest;
    logic [BinW-1:0]  r_rbin, n_rbin;
    logic [SlotW-1:0] r_rslot, n_rslot;
    logic [SlotW-1:0] r_fcnt, n_fcnt;
    logic [Depth-1:0] r_vld;
    logic             r_pend, r_pend_last, r_pend_vld;
    logic             r_ovalid, n_ovalid;
    logic             r_svalid, n_svalid;
    fwi_pkg::t_word   r_odata, r_sdata;
    logic             r_olast, r_slast;

    logic             wr_en, last_bin, rd_en, rd_last, out_take, out_load;
    logic [AddrW-1:0] wr_addr, rd_addr;
    logic [1:0]       occ;
    logic [SlotW-1:0] next_oldest;
    fwi_pkg::t_word   ram_q, rd_data;

    assign o_in_stall = (r_state != fwi_pkg::ST_IDLE);
    assign wr_en      = (r_state == fwi_pkg::ST_IDLE) && i_in_valid;
    assign last_bin   = (r_wbin == LastBin);
    assign wr_addr    = AddrW'(int'(r_oldest) * BINS_PER_FRAME + int'(r_wbin));
    assign rd_addr    = AddrW'(int'(r_rslot) * BINS_PER_FRAME + int'(r_rbin));
    assign rd_last    = (r_rbin == LastBin) && (r_fcnt == LastSlot);
    assign next_oldest = (r_oldest == LastSlot) ? '0 : r_oldest + 1'b1;

    assign out_take = r_ovalid && !i_out_stall;
    assign out_load = !r_ovalid || out_take;
    assign occ      = {1'b0, r_ovalid} + {1'b0, r_svalid} + {1'b0, r_pend};
    assign rd_en    = (r_state == fwi_pkg::ST_READ)
                      && ((occ < 2'd2) || ((occ == 2'd2) && out_take));
    assign rd_data  = r_pend_vld ? ram_q : '0;

    fwi_ram #(
        .WIDTH(fwi_pkg::DATA_W),
        .DEPTH(Depth)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(i_bin_value),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(ram_q)
    );

    always_comb begin
        n_state  = r_state;
        n_wbin   = r_wbin;
        n_oldest = r_oldest;
        n_rbin   = r_rbin;
        n_rslot  = r_rslot;
        n_fcnt   = r_fcnt;
        unique case (r_state)
            fwi_pkg::ST_IDLE: begin
                if (wr_en) begin
                    if (last_bin) begin
                        n_wbin   = '0;
                        n_oldest = next_oldest;
                        n_rslot  = next_oldest;
                        n_rbin   = '0;
                        n_fcnt   = '0;
                        n_state  = fwi_pkg::ST_READ;
                    end else begin
                        n_wbin = r_wbin + 1'b1;
                    end
                end
            end
            fwi_pkg::ST_READ: begin
                if (rd_en) begin
                    if (r_fcnt == LastSlot) begin
                        n_fcnt  = '0;
                        n_rslot = r_oldest;
                        n_rbin  = r_rbin + 1'b1;
                        if (rd_last) begin
                            n_state = fwi_pkg::ST_IDLE;
                        end
                    end else begin
                        n_fcnt  = r_fcnt + 1'b1;
                        n_rslot = (r_rslot == LastSlot) ? '0 : r_rslot + 1'b1;
                    end
                end
            end
            default: n_state = fwi_pkg::ST_IDLE;
        endcase

        if (out_load) begin
            n_ovalid = r_svalid || r_pend;
            n_svalid = r_svalid && r_pend;
        end else begin
            n_ovalid = 1'b1;
            n_svalid = r_svalid || r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= fwi_pkg::ST_IDLE;
            r_wbin   <= '0;
            r_oldest <= '0;
            r_rbin   <= '0;
            r_rslot  <= '0;
            r_fcnt   <= '0;
            r_vld    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wbin   <= n_wbin;
            r_oldest <= n_oldest;
            r_rbin   <= n_rbin;
            r_rslot  <= n_rslot;
            r_fcnt   <= n_fcnt;
            r_pend   <= rd_en;
            r_ovalid <= n_ovalid;
            r_svalid <= n_svalid;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pend_last <= rd_last;
            r_pend_vld  <= r_vld[rd_addr];
        end
        if (out_load) begin
            if (r_svalid) begin
                r_odata <= r_sdata;
                r_olast <= r_slast;
            end else if (r_pend) begin
                r_odata <= rd_data;
                r_olast <= r_pend_last;
            end
        end
        if (r_pend && !(out_load && !r_svalid)) begin
            r_sdata <= rd_data;
            r_slast <= r_pend_last;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_window_value = r_odata;
    assign o_is_last      = r_olast;

endmodule

FILE: hw/rtl/fwi_checker.sv
// ----------------------------------------------------------------------------
// Frame window interleaver port checker
// Checks the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module fwi_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [31:0]           i_bin_value,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input fwi_pkg::t_word        o_window_value,
    input logic                  o_is_last
);

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output item present straight after reset.");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_window_value) && $stable(o_is_last))
        else $error("Stalled output item changed.");

    a_stall_after_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("Input stall rose without a closing item.");

    a_in_open_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("Input stalled straight after reset.");

endmodule

bind frame_window_interleaver_unit fwi_checker u_fwi_checker (.*);

FILE: dv/frame_window_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame window interleaver checker
// Watches both channels of the frame window interleaver. It keeps its own
// copy of the frame window, works out the interleaved readout that each
// closing bin causes, and compares every accepted result against the oldest
// value still due. It reports the mismatch count and the number of results
// still outstanding.
// ----------------------------------------------------------------------------
module frame_window_checker #(
    parameter int BINS_PER_FRAME   = 8,
    parameter int FRAMES_IN_WINDOW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  fwi_pkg::t_word i_bin_value,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  fwi_pkg::t_word i_window_value,
    input  logic           i_is_last,
    output int             o_mismatches,
    output int             o_pending
);

    localparam int ReadoutLen = BINS_PER_FRAME * FRAMES_IN_WINDOW;
    localparam int ReportMax  = 10;

    typedef struct packed {
        fwi_pkg::t_word value;
        logic           last;
    } t_window_result;

    fwi_pkg::t_word frame_store [FRAMES_IN_WINDOW][BINS_PER_FRAME];
    int unsigned    next_bin;
    int unsigned    oldest_slot;
    t_window_result expected_readout [$];

    task automatic take_bin(input fwi_pkg::t_word value);
        int unsigned slot;
        int unsigned count;
        frame_store[oldest_slot][next_bin] = value;
        if (next_bin + 1 < BINS_PER_FRAME) begin
            next_bin++;
        end else begin
            next_bin    = 0;
            oldest_slot = (oldest_slot + 1 >= FRAMES_IN_WINDOW) ? 0 : oldest_slot + 1;
            count       = 0;
            for (int b = 0; b < BINS_PER_FRAME; b++) begin
                slot = oldest_slot;
                for (int f = 0; f < FRAMES_IN_WINDOW; f++) begin
                    expected_readout.push_back('{value: frame_store[slot][b],
                                                 last: (count + 1 == ReadoutLen)});
                    count++;
                    slot = (slot + 1 >= FRAMES_IN_WINDOW) ? 0 : slot + 1;
                end
            end
        end
    endtask

    task automatic check_result(input fwi_pkg::t_word value, input logic last);
        t_window_result due;
        if (expected_readout.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= ReportMax) begin
                $display("%0t: result with nothing due: value %h last %b",
                         $realtime, value, last);
            end
        end else begin
            due = expected_readout.pop_front();
            if (due.value !== value || due.last !== last) begin
                o_mismatches++;
                if (o_mismatches <= ReportMax) begin
                    $display({"%0t: readout mismatch: expected value %h last %b, ",
                              "got value %h last %b"},
                             $realtime, due.value, due.last, value, last);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (frame_store[s, b]) begin
                frame_store[s][b] = '0;
            end
            next_bin     = 0;
            oldest_slot  = 0;
            expected_readout.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                check_result(i_window_value, i_is_last);
            end
            if (i_in_valid && !i_in_stall) begin
                take_bin(i_bin_value);
            end
        end
        o_pending = expected_readout.size();
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame window interleaver testbench
// Feeds range-bin values into the frame window interleaver in bursts with
// random gaps, first a few frames of edge values and then random frames,
// while the output side stalls in changing patterns. A separate checker
// predicts each window readout and compares it; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int BINS_PER_FRAME   = 8;
    localparam int FRAMES_IN_WINDOW = 8;
    localparam int RandomBins       = 156;
    localparam int CycleLimit       = 200000;
    localparam int DrainCycles      = 16;

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    fwi_pkg::t_word i_bin_value = '0;
    logic           i_out_stall = 1'b0;
    logic           o_in_stall;
    logic           o_out_valid;
    fwi_pkg::t_word o_window_value;
    logic           o_is_last;

    int    mismatches;
    int    pending;
    int    cycle_count;
    int    burst_left;
    int    stall_phase_left;
    int    stall_mode;
    logic  stall_toggle;

    always #5 i_clk = ~i_clk;

    frame_window_interleaver_unit #(
        .BINS_PER_FRAME  (BINS_PER_FRAME),
        .FRAMES_IN_WINDOW(FRAMES_IN_WINDOW)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_bin_value   (i_bin_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_window_value(o_window_value),
        .o_is_last     (o_is_last)
    );

    frame_window_checker #(
        .BINS_PER_FRAME  (BINS_PER_FRAME),
        .FRAMES_IN_WINDOW(FRAMES_IN_WINDOW)
    ) checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_bin_value   (i_bin_value),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_window_value(o_window_value),
        .i_is_last     (o_is_last),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    // The output side moves between phases of no stall, light stall,
    // heavy stall and alternate-cycle stall, each of random length.
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode       = $urandom_range(0, 3);
            stall_phase_left = $urandom_range(5, 60);
        end
        stall_phase_left--;
        stall_toggle = ~stall_toggle;
        case (stall_mode)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_out_stall <= stall_toggle;
            end
        endcase
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("frame_window_interleaver_unit verification failed");
            $finish;
        end
    end

    task automatic send_bin(input fwi_pkg::t_word value);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_bin_value <= value;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic fwi_pkg::t_word random_bin();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        stall_toggle     = 1'b0;
        stall_phase_left = 0;
        burst_left       = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edge values first, then walking ones and zeros, so that the early
        // readouts also show the never-written frames as zeros.
        send_bin(32'h0000_0000);
        send_bin(32'hFFFF_FFFF);
        send_bin(32'h0000_0001);
        send_bin(32'h8000_0000);
        send_bin(32'hAAAA_AAAA);
        send_bin(32'h5555_5555);
        send_bin(32'h7FFF_FFFF);
        send_bin(32'hFFFF_FFFE);
        for (int b = 0; b < BINS_PER_FRAME; b++) begin
            send_bin(32'h1 << (b * 4 + 1));
        end
        for (int b = 0; b < BINS_PER_FRAME; b++) begin
            send_bin(~(32'h1 << (b * 4 + 2)));
        end

        for (int n = 0; n < RandomBins; n++) begin
            send_bin(random_bin());
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        if (mismatches == 0 && pending == 0) begin
            $display("frame_window_interleaver_unit verification clean");
        end else begin
            $display("frame_window_interleaver_unit verification failed");
        end
        $finish;
    end

endmodule
